// File: hw/rtl/ppid_pkg.sv
// -----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants of the positional PID controller with integral
// separation and anti-windup: register map, field widths and the groups of
// signals that travel between the top level and the datapath.
// -----------------------------------------------------------------------------
package ppid_pkg;

   // field widths fixed by the register map and the result format
   localparam int GAIN_W     = 16;
   localparam int EMAX_W     = 16;
   localparam int IMAX_W     = 23;
   localparam int OMAX_W     = 15;
   localparam int INTEG_W    = 24;
   localparam int DRIVE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_KP           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI           = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD           = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_MAX   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ABS_OUTPUT   = 3'd6;

   // reset values of the registers
   localparam logic [EMAX_W-1:0] ERROR_MAX_RST    = 16'hFFFF;
   localparam logic [IMAX_W-1:0] INTEGRAL_MAX_RST = 23'h7FFFFF;
   localparam logic [OMAX_W-1:0] OUTPUT_MAX_RST   = 15'h7FFF;

   // controller settings
   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
      logic [EMAX_W-1:0] error_max;
      logic [IMAX_W-1:0] integral_max;
      logic [OMAX_W-1:0] output_max;
      logic              abs_output;
   } ppid_cfg_type;

   // one result beat
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      saturated;
   } ppid_result_type;

endpackage

// File: hw/rtl/positional_pid_integral_separation_top.sv
// -----------------------------------------------------------------------------
// positional_pid_integral_separation_top
// Positional PID controller with integral separation, integral clamp and
// output saturation, one sample per cycle while the receiver keeps up.
// -----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per sample, setpoint and measurement in tdata.
//   rsp channel: one beat per sample, drive in tdata, saturated in tuser.
//   csr channel: register index and write data, always ready; write only
//   while no sample is in flight.
// The sample waits in the input register and moves into the result register
// once that register is empty or its beat is taken by the receiver.
// Throughput: one sample per cycle unless the receiver stalls; the integral and
// last error update as each sample leaves the input register, for the next to see.
// Reset clears the controller state (integral and last error), the valid
// flags and loads the register defaults (gains zero, limits at maximum).
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more sample; after that req_tready drops
// until the result is taken.
// -----------------------------------------------------------------------------
module positional_pid_integral_separation_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int GAIN_FRAC    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [SAMPLE_WIDTH-1:0] setpoint, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] measurement
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // result output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] drive
   output logic [ppid_pkg::DRIVE_W-1:0]        rsp_tdata,
   // [0] saturated
   output logic                                rsp_tuser,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppid_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SW = SAMPLE_WIDTH;

   ppid_pkg::ppid_cfg_type          cfg_ff, cfg_in;
   logic signed [SW-1:0]            sp_ff, ms_ff;
   logic                            in_valid_ff, in_valid_in;
   logic signed [SW:0]              prev_err_ff;
   logic signed [ppid_pkg::INTEG_W-1:0] integral_ff;
   ppid_pkg::ppid_result_type       result_ff;
   logic                            out_valid_ff, out_valid_in;

   logic                            advance;
   logic                            req_beat;
   logic signed [SW:0]              error;
   logic signed [ppid_pkg::INTEG_W-1:0] integral_next;
   ppid_pkg::ppid_result_type       result;

   // pipeline control
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_beat    = req_tvalid && req_tready;
   assign in_valid_in = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign csr_ready   = 1'b1;

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ppid_pkg::REG_KP:           cfg_in.kp = csr_data[ppid_pkg::GAIN_W-1:0];
            ppid_pkg::REG_KI:           cfg_in.ki = csr_data[ppid_pkg::GAIN_W-1:0];
            ppid_pkg::REG_KD:           cfg_in.kd = csr_data[ppid_pkg::GAIN_W-1:0];
            ppid_pkg::REG_ERROR_MAX:    cfg_in.error_max = csr_data[ppid_pkg::EMAX_W-1:0];
            ppid_pkg::REG_INTEGRAL_MAX: cfg_in.integral_max = csr_data[ppid_pkg::IMAX_W-1:0];
            ppid_pkg::REG_OUTPUT_MAX:   cfg_in.output_max = csr_data[ppid_pkg::OMAX_W-1:0];
            ppid_pkg::REG_ABS_OUTPUT:   cfg_in.abs_output = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp           <= '0;
         cfg_ff.ki           <= '0;
         cfg_ff.kd           <= '0;
         cfg_ff.error_max    <= ppid_pkg::ERROR_MAX_RST;
         cfg_ff.integral_max <= ppid_pkg::INTEGRAL_MAX_RST;
         cfg_ff.output_max   <= ppid_pkg::OUTPUT_MAX_RST;
         cfg_ff.abs_output   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         sp_ff <= req_tdata[SW-1:0];
         ms_ff <= req_tdata[2*SW-1:SW];
      end
   end

   // datapath
   ppid_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .GAIN_FRAC    (GAIN_FRAC)
   ) u_core (
      .setpoint      (sp_ff),
      .measurement   (ms_ff),
      .prev_error    (prev_err_ff),
      .integral      (integral_ff),
      .cfg           (cfg_ff),
      .error         (error),
      .integral_next (integral_next),
      .result        (result)
   );

   // controller state, updated as each sample is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         integral_ff <= '0;
      end else if (advance) begin
         prev_err_ff <= error;
         integral_ff <= integral_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff.drive;
   assign rsp_tuser  = result_ff.saturated;

   // a clamped drive never reaches the most negative code
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_tdata != {1'b1, {(ppid_pkg::DRIVE_W-1){1'b0}}}))
      else $error("drive holds the most negative code");

   // a full pipeline with a stalled receiver takes no sample
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("sample taken while both stages are blocked");

   // a processed sample always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed sample lost");

   // controller state moves only when a sample is processed
   assert property (@(posedge clock) disable iff (reset)
      (!reset && !advance) |=> ($stable(prev_err_ff) && $stable(integral_ff)))
      else $error("controller state changed without a sample");

endmodule

// File: hw/rtl/ppid_core.sv
// -----------------------------------------------------------------------------
// ppid_core
// Single-pass PID datapath: error and derivative, separated and clamped
// integral, the three gain products, scaling shift and output clamp.
// -----------------------------------------------------------------------------
module ppid_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int GAIN_FRAC    = 8
) (
   input  logic signed [SAMPLE_WIDTH-1:0]        setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]        measurement,
   input  logic signed [SAMPLE_WIDTH:0]          prev_error,
   input  logic signed [ppid_pkg::INTEG_W-1:0]   integral,
   input  ppid_pkg::ppid_cfg_type                cfg,
   output logic signed [SAMPLE_WIDTH:0]          error,
   output logic signed [ppid_pkg::INTEG_W-1:0]   integral_next,
   output ppid_pkg::ppid_result_type             result
);

   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   // an error that joins the integral is below 2^16 in magnitude
   localparam int SEP_W  = ppid_pkg::EMAX_W + 2;
   localparam int CMP_W  = (DIFF_W > SEP_W) ? DIFF_W : SEP_W;
   localparam int ACC_W  = ppid_pkg::INTEG_W + 1;
   localparam int SG_W   = ppid_pkg::GAIN_W + 1;
   localparam int P_W    = SG_W + ERR_W;
   localparam int I_W    = SG_W + ppid_pkg::INTEG_W;
   localparam int D_W    = SG_W + DIFF_W;
   localparam int TOT_W  = ((D_W > I_W) ? D_W : I_W) + 2;
   localparam int DW     = ppid_pkg::DRIVE_W;

   logic signed [DIFF_W-1:0] diff;
   logic signed [CMP_W-1:0]  err_cmp;
   logic signed [CMP_W-1:0]  emax_cmp;
   logic                     in_band;
   logic signed [SEP_W-1:0]  err_small;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  imax_acc;
   logic signed [ACC_W-1:0]  acc_clamped;
   logic signed [SG_W-1:0]   kp_s;
   logic signed [SG_W-1:0]   ki_s;
   logic signed [SG_W-1:0]   kd_s;
   logic signed [P_W-1:0]    p_term;
   logic signed [I_W-1:0]    i_term;
   logic signed [D_W-1:0]    d_term;
   logic signed [TOT_W-1:0]  total;
   logic signed [TOT_W-1:0]  shifted;
   logic signed [TOT_W-1:0]  omax_t;
   logic signed [DW-1:0]     clipped;
   logic                     sat;

   // error and derivative
   assign error = $signed({setpoint[SAMPLE_WIDTH-1], setpoint})
                - $signed({measurement[SAMPLE_WIDTH-1], measurement});
   assign diff  = $signed({error[ERR_W-1], error})
                - $signed({prev_error[ERR_W-1], prev_error});

   // integral separation: accumulate only when |e| < error_max
   assign err_cmp   = {{(CMP_W-ERR_W){error[ERR_W-1]}}, error};
   assign emax_cmp  = $signed({{(CMP_W-ppid_pkg::EMAX_W){1'b0}}, cfg.error_max});
   assign in_band   = (err_cmp < emax_cmp) && (err_cmp > -emax_cmp);
   assign err_small = err_cmp[SEP_W-1:0];
   assign acc_sum   = ACC_W'(integral)
                    + (in_band ? ACC_W'(err_small) : ACC_W'(0));

   // anti-windup clamp
   assign imax_acc = $signed({{(ACC_W-ppid_pkg::IMAX_W){1'b0}}, cfg.integral_max});
   always_comb begin
      if (acc_sum >= imax_acc) begin
         acc_clamped = imax_acc;
      end else if (acc_sum <= -imax_acc) begin
         acc_clamped = -imax_acc;
      end else begin
         acc_clamped = acc_sum;
      end
   end
   assign integral_next = acc_clamped[ppid_pkg::INTEG_W-1:0];

   // gain products, exact
   assign kp_s   = $signed({1'b0, cfg.kp});
   assign ki_s   = $signed({1'b0, cfg.ki});
   assign kd_s   = $signed({1'b0, cfg.kd});
   assign p_term = kp_s * error;
   assign i_term = ki_s * integral_next;
   assign d_term = kd_s * diff;
   assign total  = TOT_W'(p_term) + TOT_W'(i_term) + TOT_W'(d_term);

   // scale down, rounding toward minus infinity
   assign shifted = total >>> GAIN_FRAC;

   // output clamp and optional magnitude
   assign omax_t = $signed({{(TOT_W-ppid_pkg::OMAX_W){1'b0}}, cfg.output_max});
   always_comb begin
      if (shifted > omax_t) begin
         clipped = omax_t[DW-1:0];
         sat     = 1'b1;
      end else if (shifted < -omax_t) begin
         clipped = -(omax_t[DW-1:0]);
         sat     = 1'b1;
      end else begin
         clipped = shifted[DW-1:0];
         sat     = 1'b0;
      end
   end

   always_comb begin
      result.saturated = sat;
      if (cfg.abs_output && clipped[DW-1]) begin
         result.drive = -clipped;
      end else begin
         result.drive = clipped;
      end
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional PID controller with integral
// separation. A bit-exact predictor follows every accepted sample beat and
// queues the expected drive and saturation flag; a monitor compares each
// result beat in order. Directed samples hit the clamps and separation
// limits, then random settings and samples run under random idling on both
// sides, a long receiver hold-off and a stretch without gaps.
// -----------------------------------------------------------------------------
module tb;

   localparam int                             FRAC           = 8;
   localparam int                             LATENCY_PAUSE  = 4;
   localparam int                             WATCHDOG_LIMIT = 2000;
   localparam int                             RANDOM_PHASES  = 10;
   localparam int                             PHASE_ITEMS    = 68;
   localparam logic [ppid_pkg::CSR_IDX_W-1:0] REG_SPARE      = 3'd7;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // [15:0] setpoint, [31:16] measurement
   logic [31:0]                     req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // [15:0] drive
   logic [ppid_pkg::DRIVE_W-1:0]    rsp_tdata;
   // [0] saturated
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [ppid_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ppid_pkg::CSR_DATA_W-1:0] csr_data;

   // predictor state and register copy
   ppid_pkg::ppid_cfg_type          settings;
   logic signed [16:0]              last_error;
   logic signed [23:0]              integ_acc;
   ppid_pkg::ppid_result_type       pending_results[$];
   ppid_pkg::ppid_result_type       want;

   int                              mismatches = 0;
   bit                              tx_idle_on;
   bit                              rx_idle_on;
   int                              rsp_hold_cycles;
   int                              quiet_cycles;

   positional_pid_integral_separation_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one controller step: separation, integral clamp, gains, output clamp
   function automatic ppid_pkg::ppid_result_type controller_output(
      input logic signed [15:0] sp,
      input logic signed [15:0] ms);
      longint                    err, slope, acc, emax, imax, omax, total, y;
      ppid_pkg::ppid_result_type r;
      err   = longint'(sp) - longint'(ms);
      slope = err - longint'(last_error);
      emax  = longint'(settings.error_max);
      imax  = longint'(settings.integral_max);
      omax  = longint'(settings.output_max);
      acc   = longint'(integ_acc);
      if (err > -emax && err < emax)
         acc += err;
      if (acc >= imax)
         acc = imax;
      else if (acc <= -imax)
         acc = -imax;
      integ_acc  = acc[23:0];
      last_error = err[16:0];
      total = longint'(settings.kp) * err + longint'(settings.ki) * acc
              + longint'(settings.kd) * slope;
      y = total >>> FRAC;
      r.saturated = 1'b0;
      if (y > omax) begin
         y = omax;
         r.saturated = 1'b1;
      end else if (y < -omax) begin
         y = -omax;
         r.saturated = 1'b1;
      end
      if (settings.abs_output && y < 0)
         y = -y;
      r.drive = y[15:0];
      return r;
   endfunction

   // zero, all ones, a small value or anything of the given width
   function automatic logic [31:0] pick_value(input int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return mask;
         2: return $urandom_range(0, 1023) & mask;
         default: return $urandom & mask;
      endcase
   endfunction

   // send one sample beat and queue its prediction once accepted
   task automatic send_sample(input logic signed [15:0] sp, input logic signed [15:0] ms);
      int gap;
      gap = tx_idle_on ? int'($urandom_range(0, 8)) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {ms, sp};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(controller_output(sp, ms));
   endtask

   // mostly a small error around a random operating point, sometimes noise
   task automatic send_random_sample();
      logic signed [15:0] sp, ms;
      int                 base, target;
      if ($urandom_range(0, 3) != 0) begin
         base   = int'($urandom_range(0, 65535)) - 32768;
         target = base + int'($urandom_range(0, 400)) - 200;
         if (target > 32767)
            target = 32767;
         else if (target < -32768)
            target = -32768;
         ms = base[15:0];
         sp = target[15:0];
      end else begin
         sp = 16'($urandom);
         ms = 16'($urandom);
      end
      send_sample(sp, ms);
   endtask

   // stop offering samples and let every result drain out
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY_PAUSE) @(negedge clock);
   endtask

   // one register write beat; valid stays up for a following write
   task automatic write_register(input logic [ppid_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ppid_pkg::REG_KP:           settings.kp = data[ppid_pkg::GAIN_W-1:0];
         ppid_pkg::REG_KI:           settings.ki = data[ppid_pkg::GAIN_W-1:0];
         ppid_pkg::REG_KD:           settings.kd = data[ppid_pkg::GAIN_W-1:0];
         ppid_pkg::REG_ERROR_MAX:    settings.error_max = data[ppid_pkg::EMAX_W-1:0];
         ppid_pkg::REG_INTEGRAL_MAX: settings.integral_max = data[ppid_pkg::IMAX_W-1:0];
         ppid_pkg::REG_OUTPUT_MAX:   settings.output_max = data[ppid_pkg::OMAX_W-1:0];
         ppid_pkg::REG_ABS_OUTPUT:   settings.abs_output = data[0];
         default: ;
      endcase
   endtask

   // full register set with junk above each field, plus an unmapped index
   task automatic configure(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] emax,
                            input logic [31:0] imax, input logic [31:0] omax,
                            input logic [31:0] abs_on);
      wait_idle();
      write_register(REG_SPARE, $urandom);
      write_register(ppid_pkg::REG_KP, (32'($urandom) << ppid_pkg::GAIN_W) | kp);
      write_register(ppid_pkg::REG_KI, (32'($urandom) << ppid_pkg::GAIN_W) | ki);
      write_register(ppid_pkg::REG_KD, (32'($urandom) << ppid_pkg::GAIN_W) | kd);
      write_register(ppid_pkg::REG_ERROR_MAX, (32'($urandom) << ppid_pkg::EMAX_W) | emax);
      write_register(ppid_pkg::REG_INTEGRAL_MAX,
                     (32'($urandom) << ppid_pkg::IMAX_W) | imax);
      write_register(ppid_pkg::REG_OUTPUT_MAX, (32'($urandom) << ppid_pkg::OMAX_W) | omax);
      write_register(ppid_pkg::REG_ABS_OUTPUT, (32'($urandom) << 1) | abs_on);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // reset settings: zero gains, errors at the separation limit stay out
   task automatic test_defaults();
      send_sample(16'sd32767, -16'sd32768);
      send_sample(-16'sd32768, 16'sd32767);
      send_sample(16'sd0, 16'sd0);
   endtask

   // unit proportional gain against a 1000 output clamp, signed and magnitude
   task automatic test_output_clamp();
      configure(256, 0, 0, 65535, 8388607, 1000, 0);
      send_sample(16'sd1000, 16'sd0);
      send_sample(16'sd1001, 16'sd0);
      send_sample(-16'sd1000, 16'sd0);
      send_sample(-16'sd1001, 16'sd0);
      configure(256, 0, 0, 65535, 8388607, 1000, 1);
      send_sample(-16'sd1001, 16'sd0);
      send_sample(-16'sd5, 16'sd0);
      send_sample(16'sd3, 16'sd0);
   endtask

   // separation threshold, integral reaching its bound, zero limits
   task automatic test_integral_limits();
      configure(0, 256, 0, 100, 250, 32767, 0);
      repeat (4) send_sample(16'sd99, 16'sd0);
      send_sample(16'sd100, 16'sd0);
      send_sample(-16'sd100, 16'sd0);
      send_sample(-16'sd99, 16'sd0);
      configure(0, 256, 0, 65535, 0, 32767, 0);
      send_sample(16'sd5, 16'sd0);
      send_sample(-16'sd5, -16'sd32768);
      configure(256, 256, 256, 0, 1000, 32767, 0);
      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd0);
   endtask

   // random samples across random settings, both extremes included
   task automatic test_random_settings();
      int phase;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            configure(65535, 65535, 65535, 65535, 8388607, 32767, 1);
         else if (phase == 1)
            configure(0, 0, 0, 0, 0, 0, 0);
         else
            configure(pick_value(ppid_pkg::GAIN_W), pick_value(ppid_pkg::GAIN_W),
                      pick_value(ppid_pkg::GAIN_W), pick_value(ppid_pkg::EMAX_W),
                      pick_value(ppid_pkg::IMAX_W), pick_value(ppid_pkg::OMAX_W),
                      pick_value(1));
         repeat (PHASE_ITEMS) send_random_sample();
      end
   endtask

   // receiver holds off while samples keep coming, so the input stalls
   task automatic test_backpressure();
      configure(pick_value(ppid_pkg::GAIN_W), pick_value(ppid_pkg::GAIN_W),
                pick_value(ppid_pkg::GAIN_W), pick_value(ppid_pkg::EMAX_W),
                pick_value(ppid_pkg::IMAX_W), pick_value(ppid_pkg::OMAX_W), 0);
      rsp_hold_cycles = 150;
      tx_idle_on = 1'b0;
      repeat (30) send_random_sample();
      tx_idle_on = 1'b1;
   endtask

   // full rate on both sides
   task automatic test_back_to_back();
      configure(512, 64, 128, 2000, 100000, 32767, 0);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (40) send_random_sample();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // receiver: random stall per beat, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_tready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         if (rx_idle_on && $urandom_range(0, 8) != 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: drive %0d saturated %0b",
                   $signed(rsp_tdata), rsp_tuser);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (want.drive !== rsp_tdata) begin
               $error("drive: expected %0d, actual %0d", want.drive, $signed(rsp_tdata));
               mismatches++;
            end
            if (want.saturated !== rsp_tuser) begin
               $error("saturated: expected %0b, actual %0b", want.saturated, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any beat on any channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // main sequence
   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = ppid_pkg::REG_KP;
      csr_data        = '0;
      tx_idle_on      = 1'b1;
      rx_idle_on      = 1'b1;
      rsp_hold_cycles = 0;
      settings        = '{kp: '0, ki: '0, kd: '0,
                          error_max: ppid_pkg::ERROR_MAX_RST,
                          integral_max: ppid_pkg::INTEGRAL_MAX_RST,
                          output_max: ppid_pkg::OUTPUT_MAX_RST,
                          abs_output: 1'b0};
      last_error      = '0;
      integ_acc       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults();
      test_output_clamp();
      test_integral_limits();
      test_random_settings();
      test_backpressure();
      test_back_to_back();
      wait_idle();

      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ppid_pkg.sv
hw/rtl/ppid_core.sv
hw/rtl/positional_pid_integral_separation_top.sv
bench/tb.sv
